[rtl/retention_window_statistics_macros.svh]
// ----------------------------------------------------------------------------
// Retention window statistics assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RETENTION_WINDOW_STATISTICS_MACROS_SVH
`define RETENTION_WINDOW_STATISTICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rws_pkg.sv]
// ----------------------------------------------------------------------------
// Retention window statistics package
// Request and status codes, controller states and the control interface.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int TIME_W  = 64;
  localparam int VAL_W   = 32;
  localparam int ENTRY_W = TIME_W + VAL_W + 1;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_AVG    = 2'd1,
    REQ_MIN    = 2'd2,
    REQ_MAX    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_NONNUM = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_REC,
    ST_EV_RD,
    ST_EV_CHK,
    ST_Q_BEGIN,
    ST_Q_SPAN,
    ST_Q_WALK,
    ST_POST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RESULT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rec_apply;
    logic ev_check;
    logic q_span;
    logic q_walk;
    logic div_start;
    logic finalize;
  } cmd_t;

  typedef struct packed {
    logic is_record;
    logic held_zero;
    logic rec_insert;
    logic ev_needed;
    logic walk_done;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

[rtl/retention_window_statistics.sv]
// ----------------------------------------------------------------------------
// Retention window statistics
// Time-stamped sample history with average, minimum and maximum queries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on result_value, status and entry_count for the one cycle that
// done is high, and must be captured then. A record writes the history RAM
// and then evicts expired entries one by one, each eviction reading the
// oldest entry from the history RAM and comparing it; a record that replaces
// the newest entry or is ignored does no eviction. A query walks the history,
// reading one RAM entry per cycle, a query on an empty store skips the walk,
// and an average then runs the bit-serial divider. Busy drops the cycle
// after done. No clearing pass runs after reset.
`include "retention_window_statistics_macros.svh"

module retention_window_statistics #(
  parameter int HISTORY_DEPTH = 256,
  localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               retention_seconds_we,
  input  logic [15:0]        retention_seconds,
  input  logic [1:0]         req_type,
  input  logic [63:0]        timestamp_ns,
  input  logic signed [31:0] sample_value,
  input  logic               sample_is_numeric,
  input  logic [15:0]        window_seconds,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic [CW-1:0]      entry_count
);
  import rws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  rws_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (retention_seconds_we),
    .cfg_data          (retention_seconds),
    .req_type          (req_type),
    .timestamp_ns      (timestamp_ns),
    .sample_value      (sample_value),
    .sample_is_numeric (sample_is_numeric),
    .window_seconds    (window_seconds),
    .result_value      (result_value),
    .status            (status),
    .entry_count       (entry_count)
  );

  `RWS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `RWS_ASSERT_NEXT(a_done_idle, done, !busy, "block stayed busy after delivering a result")
  `RWS_ASSERT_NOW(a_err_zero, done && status != STAT_OK, result_value == 0, "error result not zero")
  `RWS_ASSERT_NOW(a_count_max, 1'b1, entry_count <= CW'(HISTORY_DEPTH), "entry count beyond depth")

endmodule

[rtl/rws_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rws_div.sv]
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, pulses done at the end.
// ----------------------------------------------------------------------------
module rws_div #(
  parameter int NW = 40,
  parameter int DW = 9,
  localparam int KW = $clog2(NW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  logic          running;
  logic [KW-1:0] iter;
  logic [DW:0]   rem;
  logic [NW-1:0] quo;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh   = {rem[DW-1:0], quo[NW-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= KW'(NW);
      end else if (running) begin
        iter <= iter - KW'(1);
        if (iter == KW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      rem <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

[rtl/rws_datapath.sv]
// ----------------------------------------------------------------------------
// Retention window statistics datapath
// History ring, record and eviction arithmetic, window walk and result.
// ----------------------------------------------------------------------------
module rws_datapath #(
  parameter int HISTORY_DEPTH = 256,
  localparam int IW = $clog2(HISTORY_DEPTH),
  localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  rws_pkg::cmd_t       cmd,
  output rws_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          req_type,
  input  logic [63:0]         timestamp_ns,
  input  logic signed [31:0]  sample_value,
  input  logic                sample_is_numeric,
  input  logic [15:0]         window_seconds,
  output logic signed [31:0]  result_value,
  output logic [1:0]          status,
  output logic [CW-1:0]       entry_count
);
  import rws_pkg::*;

  localparam int SW = VAL_W + IW;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] x);
    return (x == IW'(HISTORY_DEPTH - 1)) ? '0 : x + IW'(1);
  endfunction

  logic [15:0]        ret;
  req_t               req;
  logic [63:0]        ts;
  logic signed [31:0] val;
  logic               num;
  logic [15:0]        win;
  logic [63:0]        limit;
  logic [63:0]        newest;
  logic [IW-1:0]      oldest;
  logic [IW-1:0]      newest_idx;
  logic [CW-1:0]      held;

  logic [63:0]        win_end;
  logic               all_cover;
  logic [IW-1:0]      walk_ptr;
  logic [CW-1:0]      kcnt;
  logic [CW-1:0]      cnt;
  logic               pv;
  logic signed [SW-1:0] sum;
  logic signed [31:0] mn;
  logic signed [31:0] mx;
  logic signed [31:0] res;
  stat_t              stat;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [63:0]        r_time;
  logic signed [31:0] r_val;
  logic               r_num;

  logic               older;
  logic               same;
  logic               full;
  logic [IW-1:0]      ins_idx;
  logic [46:0]        limit_prod;
  logic [45:0]        span;
  logic [64:0]        begin_sum;
  logic               issue;
  logic               win_break;
  logic [SW-1:0]      mag;
  logic [SW-1:0]      quo;
  logic signed [SW-1:0] avg;
  logic               div_done;

  assign r_time = ram_rdata[ENTRY_W-1 -: TIME_W];
  assign r_val  = signed'(ram_rdata[VAL_W:1]);
  assign r_num  = ram_rdata[0];

  assign older   = (held != '0) && (ts < newest);
  assign same    = (held != '0) && (ts == newest);
  assign full    = held == CW'(HISTORY_DEPTH);
  assign ins_idx = (held == '0) ? oldest : inc(newest_idx);

  assign limit_prod = (47'(ret) + 47'd1) * 47'(NS_PER_SEC);
  assign span       = 46'(win) * 46'(NS_PER_SEC);
  assign begin_sum  = {1'b0, r_time} + 65'(span);

  assign issue     = kcnt < held;
  assign win_break = !all_cover && (r_time >= win_end);

  assign ram_we    = cmd.rec_apply && !older;
  assign ram_waddr = same ? newest_idx : ins_idx;
  assign ram_wdata = {ts, val, num};
  assign ram_raddr = cmd.q_walk ? walk_ptr : oldest;

  assign mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign avg = sum[SW-1] ? -signed'(quo) : signed'(quo);

  assign sts.is_record  = req == REQ_RECORD;
  assign sts.held_zero  = held == '0;
  assign sts.rec_insert = !older && !same;
  assign sts.ev_needed  = (held != '0) && ((ts - r_time) >= limit);
  assign sts.walk_done  = pv ? (win_break || !r_num) : !issue;
  assign sts.need_div   = (req == REQ_AVG) && (stat == STAT_OK) && (cnt != '0);
  assign sts.div_done   = div_done;

  assign result_value = res;
  assign status       = stat;
  assign entry_count  = held;

  rws_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rws_div #(.NW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ret <= '0;
    end else if (cfg_we) begin
      ret <= cfg_data;
    end
  end

  // Ring bookkeeping: a full ring gives up its oldest slot to the new entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      oldest     <= '0;
      newest_idx <= '0;
    end else if (cmd.rec_apply && !older && !same) begin
      if (full) begin
        oldest <= inc(oldest);
      end else begin
        held <= held + CW'(1);
      end
      newest_idx <= ins_idx;
    end else if (cmd.ev_check && sts.ev_needed) begin
      oldest <= inc(oldest);
      held   <= held - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (cmd.q_span) begin
      pv <= 1'b0;
    end else if (cmd.q_walk) begin
      pv <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req   <= req_t'(req_type);
      ts    <= timestamp_ns;
      val   <= sample_value;
      num   <= sample_is_numeric;
      win   <= window_seconds;
      limit <= {17'd0, limit_prod};
      res   <= '0;
      stat  <= ((req_type != REQ_RECORD) && (held == '0)) ? STAT_EMPTY : STAT_OK;
    end
    if (cmd.rec_apply && !older && !same) begin
      newest <= ts;
    end
    if (cmd.q_span) begin
      all_cover <= (win == '0) || begin_sum[64];
      win_end   <= begin_sum[63:0];
      walk_ptr  <= oldest;
      kcnt      <= '0;
      sum       <= '0;
      mn        <= 32'sh7FFFFFFF;
      mx        <= 32'sh80000000;
      cnt       <= '0;
    end
    // Read data arrives the cycle after its address; pv marks it as live.
    if (cmd.q_walk) begin
      if (issue) begin
        walk_ptr <= inc(walk_ptr);
        kcnt     <= kcnt + CW'(1);
      end
      if (pv && !win_break) begin
        if (!r_num) begin
          stat <= STAT_NONNUM;
        end else begin
          sum <= sum + SW'(r_val);
          cnt <= cnt + CW'(1);
          if (r_val < mn) begin
            mn <= r_val;
          end
          if (r_val > mx) begin
            mx <= r_val;
          end
        end
      end
    end
    if (cmd.finalize && (stat == STAT_OK)) begin
      if (cnt == '0) begin
        stat <= STAT_EMPTY;
      end else begin
        unique case (req)
          REQ_AVG:    res <= avg[31:0];
          REQ_MIN:    res <= mn;
          REQ_MAX:    res <= mx;
          REQ_RECORD: res <= '0;
        endcase
      end
    end
  end

endmodule

[rtl/rws_ctrl.sv]
// ----------------------------------------------------------------------------
// Retention window statistics controller
// Sequences record, eviction, window walk, division and result delivery.
// ----------------------------------------------------------------------------
module rws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output rws_pkg::cmd_t cmd,
  input  rws_pkg::sts_t sts
);
  import rws_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts.is_record) begin
          state_next = ST_REC;
        end else if (sts.held_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_Q_BEGIN;
        end
      end
      ST_REC:       state_next = sts.rec_insert ? ST_EV_RD : ST_DONE;
      ST_EV_RD:     state_next = ST_EV_CHK;
      ST_EV_CHK:    state_next = sts.ev_needed ? ST_EV_RD : ST_DONE;
      ST_Q_BEGIN:   state_next = ST_Q_SPAN;
      ST_Q_SPAN:    state_next = ST_Q_WALK;
      ST_Q_WALK:    if (sts.walk_done) state_next = ST_POST;
      ST_POST:      state_next = sts.need_div ? ST_DIV_START : ST_RESULT;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (sts.div_done) state_next = ST_RESULT;
      ST_RESULT:    state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_REC:       cmd.rec_apply = 1'b1;
      ST_EV_CHK:    cmd.ev_check  = 1'b1;
      ST_Q_SPAN:    cmd.q_span    = 1'b1;
      ST_Q_WALK:    cmd.q_walk    = 1'b1;
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_RESULT:    cmd.finalize  = 1'b1;
      ST_DONE:      done          = 1'b1;
      default:      cmd           = '0;
    endcase
  end

endmodule
